/* hw/rtl/jog_stepper_ramp_controller_core_macros.svh */
// Assertion macros shared by the jog stepper ramp controller RTL.
`ifndef JOG_STEPPER_RAMP_CONTROLLER_CORE_MACROS_SVH
`define JOG_STEPPER_RAMP_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define JSRC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside of reset.
`define JSRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/jsrc_pkg.sv */
// Shared types and constants of the jog stepper ramp controller.
package jsrc_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int SAMPLE_W    = 10;
   localparam int USED_W      = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int SPEED_W     = 11;
   localparam int SUM_W       = SPEED_W + 1;
   localparam int ACCEL_W     = 8;
   localparam int PERIOD_W    = 16;
   localparam int DIV_CNT_W   = $clog2(PERIOD_W);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [ACCEL_W-1:0]  ACCEL_RESET     = ACCEL_W'(1);
   localparam logic [PERIOD_W-1:0] TIME_BASE_RESET = PERIOD_W'(12000);
   localparam logic [SPEED_W-1:0]  SPEED_MAX       = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_STEP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_BASE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_INVERT = 2'd2;

   typedef enum logic [2:0] {
      SPD_HOLD,
      SPD_RAMP_SPEED,
      SPD_RAMP_ZERO,
      SPD_LOAD_TARGET,
      SPD_CLEAR
   } spd_op_type;

   typedef struct packed {
      logic       latch;
      spd_op_type spd_op;
      logic       drv_on;
      logic       drv_off;
      logic       dir;
      logic       apply;
      logic       div_start;
      logic       publish;
   } cmd_type;

   typedef struct packed {
      logic jog_left;
      logic jog_right;
      logic ramp_reached;
      logic need_div;
      logic div_done;
   } status_type;

endpackage

/* hw/rtl/jsrc_divider.sv */
// Restoring divider that produces the step timer period one bit per cycle.
module jsrc_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [jsrc_pkg::PERIOD_W-1:0]  dividend,
   input  logic [jsrc_pkg::SPEED_W-1:0]   divisor,
   output logic                           done,
   output logic [jsrc_pkg::PERIOD_W-1:0]  quotient
);
   import jsrc_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PERIOD_W-1:0]  quo_ff, quo_in;
   logic [SPEED_W-1:0]   rem_ff, rem_in;
   logic [SPEED_W-1:0]   dsr_ff, dsr_in;
   logic [SUM_W-1:0]     trial;
   logic [SUM_W-1:0]     diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[PERIOD_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[PERIOD_W-2:0], fits};
         rem_in = fits ? diff[SPEED_W-1:0] : trial[SPEED_W-1:0];
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(PERIOD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hw/rtl/jsrc_ctrl.sv */
// Controller: tick sequencer and the five-state jog mode machine.
module jsrc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  jsrc_pkg::status_type   status,
   output jsrc_pkg::cmd_type      cmd
);
   import jsrc_pkg::*;

   typedef enum logic [4:0] {
      SEQ_IDLE  = 5'b00001,
      SEQ_EVAL  = 5'b00010,
      SEQ_APPLY = 5'b00100,
      SEQ_DIV   = 5'b01000,
      SEQ_DONE  = 5'b10000
   } seq_type;

   typedef enum logic [4:0] {
      MODE_STOP      = 5'b00001,
      MODE_ACC_LEFT  = 5'b00010,
      MODE_ACC_RIGHT = 5'b00100,
      MODE_RUN_LEFT  = 5'b01000,
      MODE_RUN_RIGHT = 5'b10000
   } mode_type;

   seq_type    seq_ff, seq_in;
   mode_type   mode_ff, mode_in;
   logic       entry_ff, entry_in;
   logic       valid_ff, valid_in;
   logic       eval_mode;
   spd_op_type spd_sel;
   logic       drv_on;
   logic       drv_off;
   logic       drv_dir;
   logic       do_latch;
   logic       do_apply;
   logic       do_div_start;
   logic       do_publish;

   assign req_tready = (seq_ff == SEQ_IDLE);
   assign rsp_tvalid = valid_ff;
   assign eval_mode  = (seq_ff == SEQ_EVAL);

   assign cmd = '{latch: do_latch, spd_op: spd_sel, drv_on: drv_on, drv_off: drv_off,
                  dir: drv_dir, apply: do_apply, div_start: do_div_start,
                  publish: do_publish};

   // Mode machine, evaluated once per tick in the EVAL step.
   always_comb begin
      mode_in  = mode_ff;
      entry_in = entry_ff;
      spd_sel  = SPD_HOLD;
      drv_on   = 1'b0;
      drv_off  = 1'b0;
      drv_dir  = 1'b0;
      unique case (mode_ff) inside
         MODE_ACC_LEFT, MODE_ACC_RIGHT: begin
            spd_sel  = entry_ff ? SPD_RAMP_ZERO : SPD_RAMP_SPEED;
            drv_on   = entry_ff;
            drv_dir  = (mode_ff == MODE_ACC_RIGHT);
            entry_in = status.ramp_reached;
            if (status.ramp_reached) begin
               mode_in = (mode_ff == MODE_ACC_RIGHT) ? MODE_RUN_RIGHT : MODE_RUN_LEFT;
            end
         end
         MODE_RUN_LEFT: begin
            spd_sel  = SPD_LOAD_TARGET;
            entry_in = !status.jog_left;
            if (!status.jog_left) begin
               mode_in = MODE_STOP;
            end
         end
         MODE_RUN_RIGHT: begin
            spd_sel  = SPD_LOAD_TARGET;
            entry_in = !status.jog_right;
            if (!status.jog_right) begin
               mode_in = MODE_STOP;
            end
         end
         default: begin
            spd_sel = entry_ff ? SPD_CLEAR : SPD_HOLD;
            drv_off = entry_ff;
            if (status.jog_left) begin
               entry_in = 1'b1;
               mode_in  = MODE_ACC_LEFT;
            end else if (status.jog_right) begin
               entry_in = 1'b1;
               mode_in  = MODE_ACC_RIGHT;
            end else begin
               entry_in = 1'b0;
               mode_in  = MODE_STOP;
            end
         end
      endcase
      if (!eval_mode) begin
         mode_in  = mode_ff;
         entry_in = entry_ff;
         spd_sel  = SPD_HOLD;
         drv_on   = 1'b0;
         drv_off  = 1'b0;
      end
   end

   // Tick sequencer and result hand-off.
   always_comb begin
      seq_in       = seq_ff;
      valid_in     = valid_ff;
      do_latch     = 1'b0;
      do_apply     = 1'b0;
      do_div_start = 1'b0;
      do_publish   = 1'b0;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      unique case (seq_ff)
         SEQ_IDLE: begin
            if (req_tvalid) begin
               do_latch = 1'b1;
               seq_in   = SEQ_EVAL;
            end
         end
         SEQ_EVAL: begin
            seq_in = SEQ_APPLY;
         end
         SEQ_APPLY: begin
            do_apply     = 1'b1;
            do_div_start = status.need_div;
            seq_in       = status.need_div ? SEQ_DIV : SEQ_DONE;
         end
         SEQ_DIV: begin
            if (status.div_done) begin
               seq_in = SEQ_DONE;
            end
         end
         SEQ_DONE: begin
            if (!valid_ff || rsp_tready) begin
               do_publish = 1'b1;
               valid_in   = 1'b1;
               seq_in     = SEQ_IDLE;
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= SEQ_IDLE;
         mode_ff  <= MODE_STOP;
         entry_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         seq_ff   <= seq_in;
         mode_ff  <= mode_in;
         entry_ff <= entry_in;
         valid_ff <= valid_in;
      end
   end

endmodule

/* hw/rtl/jsrc_datapath.sv */
// Datapath: settings, speed and driver registers, timer programming, result register.
module jsrc_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  jsrc_pkg::cmd_type               cmd,
   output jsrc_pkg::status_type            status,
   input  logic                            req_left_switch_pin,
   input  logic                            req_right_switch_pin,
   input  logic [jsrc_pkg::SAMPLE_W-1:0]   req_speed_sample,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [jsrc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [jsrc_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                            rsp_enable_pin,
   output logic                            rsp_direction_pin,
   output logic [jsrc_pkg::SPEED_W-1:0]    rsp_current_speed,
   output logic                            rsp_timer_running,
   output logic [jsrc_pkg::PERIOD_W-1:0]   rsp_timer_period,
   output logic                            rsp_timer_reloaded
);
   import jsrc_pkg::*;

   logic [ACCEL_W-1:0]  accel_ff;
   logic [PERIOD_W-1:0] tbase_ff;
   logic                inv_ff;

   logic                jog_left_ff, jog_right_ff;
   logic [SAMPLE_W-1:0] sample_ff;

   logic [SPEED_W-1:0]  speed_ff, speed_in;
   logic [SPEED_W-1:0]  last_ff;
   logic                drv_ff, dir_ff;
   logic                timer_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic                reload_ff;

   logic [SAMPLE_W-1:0] target;
   logic [SPEED_W-1:0]  ramp_base;
   logic [SUM_W-1:0]    ramp_sum;
   logic [SPEED_W-1:0]  ramp_sat;
   logic                changed;
   logic [SPEED_W-1:0]  clamped;
   logic                div_done;
   logic [PERIOD_W-1:0] quotient;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff <= ACCEL_RESET;
         tbase_ff <= TIME_BASE_RESET;
         inv_ff   <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ACCEL_STEP:    accel_ff <= csr_data[ACCEL_W-1:0];
            CSR_TIME_BASE:     tbase_ff <= csr_data[PERIOD_W-1:0];
            CSR_ENABLE_INVERT: inv_ff   <= csr_data[0];
            default:           ;
         endcase
      end
   end

   // The left switch wins when both are pressed.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         jog_left_ff  <= !req_left_switch_pin;
         jog_right_ff <= req_left_switch_pin && !req_right_switch_pin;
         sample_ff    <= SAMPLE_W'(req_speed_sample[USED_W-1:0]);
      end
   end

   assign target    = (jog_left_ff || jog_right_ff) ? sample_ff : '0;
   assign ramp_base = (cmd.spd_op == SPD_RAMP_ZERO) ? '0 : speed_ff;
   assign ramp_sum  = {1'b0, ramp_base} + SUM_W'(accel_ff);
   assign ramp_sat  = ramp_sum[SUM_W-1] ? SPEED_MAX : ramp_sum[SPEED_W-1:0];

   always_comb begin
      case (cmd.spd_op) inside
         SPD_RAMP_SPEED, SPD_RAMP_ZERO: speed_in = ramp_sat;
         SPD_LOAD_TARGET:               speed_in = SPEED_W'(target);
         SPD_CLEAR:                     speed_in = '0;
         default:                       speed_in = speed_ff;
      endcase
   end

   // Clamping to the time base keeps the divisor within the speed width.
   assign changed = (speed_ff != last_ff);
   assign clamped = ({{(PERIOD_W-SPEED_W){1'b0}}, speed_ff} > tbase_ff)
                    ? tbase_ff[SPEED_W-1:0] : speed_ff;

   jsrc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (tbase_ff),
      .divisor  (clamped),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff  <= '0;
         last_ff   <= '0;
         drv_ff    <= 1'b0;
         dir_ff    <= 1'b0;
         timer_ff  <= 1'b0;
         period_ff <= '0;
         reload_ff <= 1'b0;
      end else begin
         speed_ff <= speed_in;
         if (cmd.drv_on) begin
            drv_ff <= 1'b1;
            dir_ff <= cmd.dir;
         end else if (cmd.drv_off) begin
            drv_ff <= 1'b0;
         end
         if (cmd.apply) begin
            reload_ff <= changed;
            if (changed) begin
               timer_ff <= 1'b0;
               last_ff  <= speed_ff;
            end
         end
         if (div_done) begin
            period_ff <= quotient;
            timer_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_enable_pin     <= drv_ff ^ inv_ff;
         rsp_direction_pin  <= dir_ff;
         rsp_current_speed  <= speed_ff;
         rsp_timer_running  <= timer_ff;
         rsp_timer_period   <= period_ff;
         rsp_timer_reloaded <= reload_ff;
      end
   end

   assign status.jog_left     = jog_left_ff;
   assign status.jog_right    = jog_right_ff;
   assign status.ramp_reached = (ramp_sat >= SPEED_W'(target));
   assign status.need_div     = changed && (clamped != '0);
   assign status.div_done     = div_done;

endmodule

/* hw/rtl/jog_stepper_ramp_controller_core.sv */
// Top level of the jog stepper ramp controller.
`include "jog_stepper_ramp_controller_core_macros.svh"

// Each request transfer is one 1 ms tick carrying the two active-low jog switch
// pins and a speed sample; each tick yields exactly one response transfer with
// the driver pin levels, the commanded speed and the step timer setup. After
// acceptance a tick passes the EVAL and APPLY steps, then the DIV step when a
// new step period has to be computed, and then DONE; the DIV step lasts until
// the restoring divider has resolved all 16 quotient bits of time_base /
// clamped speed, at one quotient bit per cycle. The result sits
// in an output register, so a new tick can be accepted while the previous
// result still waits for its transfer. Configuration writes (index 0
// accel_step, 1 time_base, 2 enable_invert) are always accepted and should
// only be issued while no tick is in flight.
module jog_stepper_ramp_controller_core (
   input  logic                            clock,
   input  logic                            reset,
   // Request: [0] left_switch_pin, [1] right_switch_pin, [11:2] speed_sample.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,
   // Response: [0] enable_pin, [1] direction_pin, [12:2] current_speed,
   // [13] timer_running, [29:14] timer_period, [30] timer_reloaded.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [jsrc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [jsrc_pkg::CSR_DATA_W-1:0] csr_data
);
   import jsrc_pkg::*;

   cmd_type             cmd;
   status_type          status;
   logic                enable_pin;
   logic                direction_pin;
   logic [SPEED_W-1:0]  current_speed;
   logic                timer_running;
   logic [PERIOD_W-1:0] timer_period;
   logic                timer_reloaded;
   logic                req_xfer;
   logic                rsp_drain;
   logic                timer_shown;

   jsrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   jsrc_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_left_switch_pin  (req_tdata[0]),
      .req_right_switch_pin (req_tdata[1]),
      .req_speed_sample     (req_tdata[SAMPLE_W+1:2]),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .rsp_enable_pin       (enable_pin),
      .rsp_direction_pin    (direction_pin),
      .rsp_current_speed    (current_speed),
      .rsp_timer_running    (timer_running),
      .rsp_timer_period     (timer_period),
      .rsp_timer_reloaded   (timer_reloaded)
   );

   assign rsp_tdata = {1'b0, timer_reloaded, timer_period, timer_running,
                       current_speed, direction_pin, enable_pin};

   // Handshake terms used by the checks below.
   assign req_xfer    = req_tvalid && req_tready;
   assign rsp_drain   = rsp_tvalid && rsp_tready && !cmd.publish;
   assign timer_shown = rsp_tvalid && timer_running;

   // A tick in flight blocks the next request transfer.
   `JSRC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_xfer, !req_tready, "tick overlap")
   // A taken result is never offered twice.
   `JSRC_ASSERT_NEXT(a_no_repeat, clock, reset, rsp_drain, !rsp_tvalid, "response repeated")
   // A running step timer always has a programmed, nonzero period.
   `JSRC_ASSERT_IMPLY(a_period_nonzero, clock, reset, timer_shown, timer_period != '0, "no period")

endmodule
